// ===== hw/rtl/dgd_pkg.sv =====
// ----------------------------------------------------------------------------
// dgd_pkg: shared constants for the drag gesture detector
// Holds the event and action codes, the register indexes and the fixed widths
// of the configuration registers and of the event counter.
// ----------------------------------------------------------------------------
package dgd_pkg;

    localparam int OP_BITS     = 3;
    localparam int ACT_BITS    = 3;
    localparam int THR_BITS    = 12;
    localparam int TMO_BITS    = 20;
    localparam int CNT_BITS    = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 20;

    // squared threshold: up to 4095 * 4095
    localparam int THR_SQ_BITS = 2 * THR_BITS;
    // a squared distance is only worked out for deltas below 2^THR_BITS
    localparam int DIST_SUM_BITS = 2 * THR_BITS + 1;

    localparam logic [THR_BITS-1:0] THR_MIN   = THR_BITS'(4);
    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(14);
    localparam logic [TMO_BITS-1:0] TMO_RESET = TMO_BITS'(10000);
    localparam logic [THR_SQ_BITS-1:0] THR_SQ_RESET = THR_SQ_BITS'(14 * 14);
    localparam logic [CNT_BITS-1:0] CNT_STEP = CNT_BITS'(32'h0000_0001);

    // event codes
    localparam logic [OP_BITS-1:0] OP_LDOWN  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_RDOWN  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_RUP    = 3'd2;
    localparam logic [OP_BITS-1:0] OP_MOVE   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_OTHER  = 3'd4;
    localparam logic [OP_BITS-1:0] OP_ARM    = 3'd5;
    localparam logic [OP_BITS-1:0] OP_NONACT = 3'd6;

    // action codes
    localparam logic [ACT_BITS-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_LEFT  = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_START = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_END   = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_CLICK = 3'd4;
    localparam logic [ACT_BITS-1:0] ACT_MOVE  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT_MS     = 2'd1;

endpackage

// ===== hw/rtl/dgd_dist.sv =====
// ----------------------------------------------------------------------------
// dgd_dist: drag distance check
// Flags when the pointer lies at least the drag threshold away from the press
// origin, comparing squared Euclidean distance against the squared threshold.
// ----------------------------------------------------------------------------
module dgd_dist #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0]          pos_x,
    input  logic signed [COORD_BITS-1:0]          pos_y,
    input  logic signed [COORD_BITS-1:0]          org_x,
    input  logic signed [COORD_BITS-1:0]          org_y,
    input  logic [dgd_pkg::THR_SQ_BITS-1:0]       thr_sq,
    output logic                                  far
);

    localparam int DW = COORD_BITS + 1;
    localparam int SQ_BITS = (DW < dgd_pkg::THR_BITS) ? DW : dgd_pkg::THR_BITS;
    localparam int SUM_BITS = dgd_pkg::DIST_SUM_BITS;
    localparam int PROD_BITS = 2 * SQ_BITS;

    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic [DW-1:0]          ax;
    logic [DW-1:0]          ay;
    logic                   big;
    logic [SQ_BITS-1:0]     ax_lo;
    logic [SQ_BITS-1:0]     ay_lo;
    logic [2*SQ_BITS-1:0]   sq_x;
    logic [2*SQ_BITS-1:0]   sq_y;
    logic [SUM_BITS-1:0]    dist_sq;

    always_comb begin
        dx = DW'(pos_x) - DW'(org_x);
        dy = DW'(pos_y) - DW'(org_y);
        ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
        // a delta past the widest threshold is always far enough
        big = ((ax >> SQ_BITS) != '0) || ((ay >> SQ_BITS) != '0);
        ax_lo = ax[SQ_BITS-1:0];
        ay_lo = ay[SQ_BITS-1:0];
        sq_x = PROD_BITS'(ax_lo) * PROD_BITS'(ax_lo);
        sq_y = PROD_BITS'(ay_lo) * PROD_BITS'(ay_lo);
        dist_sq = SUM_BITS'(sq_x) + SUM_BITS'(sq_y);
        far = big || (dist_sq >= SUM_BITS'(thr_sq));
    end

endmodule

// ===== hw/rtl/drag_gesture_detector_unit.sv =====
// ----------------------------------------------------------------------------
// drag_gesture_detector_unit: right-button drag gesture detector
// Input beats are pointer events (kind, position, injected flag, timestamp).
// Each event gives exactly one result beat: swallow flag, action code, the
// event position, the press origin on gesture start and the handled count.
// Configuration writes on cfg_* set the drag threshold (index 0) and the
// press timeout in ms (index 1); cfg_ready is always high, and writes are
// expected only while no event is in flight.
// An accepted event sits in the input register, is decided by the
// combinational logic (one pair of 12x12 squares and a compare set the
// path) and lands in the result register. One event per cycle is
// sustained while m_ready is high.
// When the receiver stalls, the result register holds and the input register
// keeps taking one more beat; after that s_ready drops until the result moves.
// Reset clears all gesture state, the counter and both pipeline stages and
// restores the threshold to 14 and the timeout to 10000 ms.
// ----------------------------------------------------------------------------
module drag_gesture_detector_unit #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dgd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [dgd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // events in
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [dgd_pkg::OP_BITS-1:0]           s_op,
    input  logic signed [COORD_BITS-1:0]          s_pos_x,
    input  logic signed [COORD_BITS-1:0]          s_pos_y,
    input  logic                                  s_injected,
    input  logic [TIME_BITS-1:0]                  s_now_ms,
    // results out
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_swallow,
    output logic [dgd_pkg::ACT_BITS-1:0]          m_action,
    output logic signed [COORD_BITS-1:0]          m_out_x,
    output logic signed [COORD_BITS-1:0]          m_out_y,
    output logic signed [COORD_BITS-1:0]          m_origin_x,
    output logic signed [COORD_BITS-1:0]          m_origin_y,
    output logic [dgd_pkg::CNT_BITS-1:0]          m_event_count
);

    localparam int TMO_BITS = dgd_pkg::TMO_BITS;
    localparam int CMP_BITS = (TIME_BITS > TMO_BITS) ? TIME_BITS : TMO_BITS;
    localparam int THR_SQ_W = dgd_pkg::THR_SQ_BITS;

    // configuration
    logic [dgd_pkg::THR_SQ_BITS-1:0]  thr_sq_reg;
    logic [TMO_BITS-1:0]              timeout_reg;
    logic [dgd_pkg::THR_BITS-1:0]     thr_clamped;

    // input stage
    logic                             in_vld_reg;
    logic [dgd_pkg::OP_BITS-1:0]      in_op_reg;
    logic signed [COORD_BITS-1:0]     in_x_reg;
    logic signed [COORD_BITS-1:0]     in_y_reg;
    logic                             in_inj_reg;
    logic [TIME_BITS-1:0]             in_now_reg;

    // gesture state
    logic                             pressed_reg, pressed_next;
    logic                             gesture_reg, gesture_next;
    logic signed [COORD_BITS-1:0]     press_x_reg, press_x_next;
    logic signed [COORD_BITS-1:0]     press_y_reg, press_y_next;
    logic [TIME_BITS-1:0]             press_time_reg, press_time_next;
    logic                             skip_press_reg, skip_press_next;
    logic                             skip_release_reg, skip_release_next;
    logic [dgd_pkg::CNT_BITS-1:0]     count_reg, count_next;

    // result stage
    logic                             out_vld_reg;
    logic                             swallow_reg, swallow_next;
    logic [dgd_pkg::ACT_BITS-1:0]     action_reg, action_next;
    logic signed [COORD_BITS-1:0]     out_x_reg;
    logic signed [COORD_BITS-1:0]     out_y_reg;
    logic signed [COORD_BITS-1:0]     origin_x_reg, origin_x_next;
    logic signed [COORD_BITS-1:0]     origin_y_reg, origin_y_next;

    logic                             advance;
    logic                             far;
    logic                             timed_out;
    logic                             pressed_eff;
    logic [TIME_BITS-1:0]             elapsed;

    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    assign thr_clamped = (cfg_data[dgd_pkg::THR_BITS-1:0] < dgd_pkg::THR_MIN) ?
                         dgd_pkg::THR_MIN : cfg_data[dgd_pkg::THR_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_sq_reg  <= dgd_pkg::THR_SQ_RESET;
            timeout_reg <= dgd_pkg::TMO_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dgd_pkg::CFG_DRAG_THRESHOLD: begin
                    thr_sq_reg <= THR_SQ_W'(thr_clamped) * THR_SQ_W'(thr_clamped);
                end
                dgd_pkg::CFG_TIMEOUT_MS:     timeout_reg <= cfg_data[TMO_BITS-1:0];
                default: ;
            endcase
        end
    end

    dgd_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .pos_x  (in_x_reg),
        .pos_y  (in_y_reg),
        .org_x  (press_x_reg),
        .org_y  (press_y_reg),
        .thr_sq (thr_sq_reg),
        .far    (far)
    );

    assign elapsed   = in_now_reg - press_time_reg;
    assign timed_out = pressed_reg && !gesture_reg && (press_time_reg != '0) &&
                       (CMP_BITS'(elapsed) > CMP_BITS'(timeout_reg));
    assign pressed_eff = pressed_reg && !timed_out;

    always_comb begin
        pressed_next      = pressed_reg;
        gesture_next      = gesture_reg;
        press_x_next      = press_x_reg;
        press_y_next      = press_y_reg;
        press_time_next   = press_time_reg;
        skip_press_next   = skip_press_reg;
        skip_release_next = skip_release_reg;
        count_next        = count_reg;
        swallow_next      = 1'b0;
        action_next       = dgd_pkg::ACT_NONE;
        origin_x_next     = '0;
        origin_y_next     = '0;

        if (in_op_reg == dgd_pkg::OP_ARM) begin
            skip_press_next   = 1'b1;
            skip_release_next = 1'b1;
        end else if (in_op_reg <= dgd_pkg::OP_OTHER) begin
            count_next = count_reg + dgd_pkg::CNT_STEP;
            if (in_op_reg == dgd_pkg::OP_RDOWN && skip_press_reg) begin
                skip_press_next = 1'b0;
            end else if (in_op_reg == dgd_pkg::OP_RUP && skip_release_reg) begin
                skip_release_next = 1'b0;
            end else if (!in_inj_reg) begin
                if (timed_out) begin
                    pressed_next    = 1'b0;
                    press_time_next = '0;
                end
                case (in_op_reg)
                    dgd_pkg::OP_LDOWN: begin
                        action_next = dgd_pkg::ACT_LEFT;
                    end
                    dgd_pkg::OP_RDOWN: begin
                        pressed_next    = 1'b1;
                        press_x_next    = in_x_reg;
                        press_y_next    = in_y_reg;
                        press_time_next = in_now_reg;
                        swallow_next    = 1'b1;
                    end
                    dgd_pkg::OP_RUP: begin
                        if (gesture_reg) begin
                            gesture_next    = 1'b0;
                            pressed_next    = 1'b0;
                            press_time_next = '0;
                            action_next     = dgd_pkg::ACT_END;
                            swallow_next    = 1'b1;
                        end else if (pressed_eff) begin
                            pressed_next    = 1'b0;
                            press_time_next = '0;
                            action_next     = dgd_pkg::ACT_CLICK;
                            swallow_next    = 1'b1;
                        end
                    end
                    dgd_pkg::OP_MOVE: begin
                        if (gesture_reg) begin
                            action_next = dgd_pkg::ACT_MOVE;
                        end else if (pressed_eff && far) begin
                            gesture_next  = 1'b1;
                            action_next   = dgd_pkg::ACT_START;
                            origin_x_next = press_x_reg;
                            origin_y_next = press_y_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg  <= s_op;
            in_x_reg   <= s_pos_x;
            in_y_reg   <= s_pos_y;
            in_inj_reg <= s_injected;
            in_now_reg <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg      <= 1'b0;
            gesture_reg      <= 1'b0;
            press_x_reg      <= '0;
            press_y_reg      <= '0;
            press_time_reg   <= '0;
            skip_press_reg   <= 1'b0;
            skip_release_reg <= 1'b0;
            count_reg        <= '0;
        end else if (advance) begin
            pressed_reg      <= pressed_next;
            gesture_reg      <= gesture_next;
            press_x_reg      <= press_x_next;
            press_y_reg      <= press_y_next;
            press_time_reg   <= press_time_next;
            skip_press_reg   <= skip_press_next;
            skip_release_reg <= skip_release_next;
            count_reg        <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            swallow_reg  <= swallow_next;
            action_reg   <= action_next;
            out_x_reg    <= in_x_reg;
            out_y_reg    <= in_y_reg;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_swallow     = swallow_reg;
    assign m_action      = action_reg;
    assign m_out_x       = out_x_reg;
    assign m_out_y       = out_y_reg;
    assign m_origin_x    = origin_x_reg;
    assign m_origin_y    = origin_y_reg;
    // the counter only moves with the beat that lands in the result register
    assign m_event_count = count_reg;

endmodule
